>>> hdl/plsc_pkg.sv
// ============================================================================
// plsc_pkg: shared definitions for the positional list store
// Capacity, derived widths, command and status codes, and the control word
// that the top level hands to every storage cell.
// ============================================================================
package plsc_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // Common width for comparing the 8-bit position against the count.
    localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;

    localparam logic signed [4:0] FOUND_NONE = -5'sd1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_REWIND = 2'd2,
        CMD_NEXT   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOTFOUND  = 2'd2,
        ST_EXHAUSTED = 2'd3
    } status_t;

    typedef struct packed {
        logic occupied;   // cell position is below the element count
        logic load;       // cell takes the inserted word
        logic take_left;  // cell takes its lower neighbor's word
    } cell_ctrl_t;

endpackage

>>> hdl/plsc_cell.sv
// ============================================================================
// plsc_cell: one storage cell of the list
// Holds one element, shifts in its lower neighbor's element on an insert
// below it, loads the new word at the insert point, and compares its element
// against the search key.
// ============================================================================
module plsc_cell (
    input  logic                 clk,
    input  plsc_pkg::cell_ctrl_t ctrl,
    input  logic signed [31:0]   left_value,
    input  logic signed [31:0]   din,
    output logic signed [31:0]   slot_value,
    output logic                 match
);
    import plsc_pkg::*;

    logic signed [31:0] slot_reg;
    logic signed [31:0] slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.take_left)
        begin
            slot_next = left_value;
        end
        else if (ctrl.load)
        begin
            slot_next = din;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot_value = slot_reg;
    assign match      = ctrl.occupied && (slot_reg == din);

endmodule

>>> hdl/positional_list_store_core.sv
// ============================================================================
// positional_list_store_core: bounded ordered list with one read cursor
// A row of storage cells that shift and compare in parallel to insert, search and read.
// ============================================================================
//
// Usage:
// The input channel (in_valid / in_ready) carries one command word with a
// value and a position. The output channel (out_valid / out_ready) returns
// exactly one result word per command, in order.
// The result of an accepted word is held in an output register and shows in
// the cycle after the word is accepted. Throughput is one word per cycle while
// the receiver takes each result; it is set by the row of cells, which all
// shift and compare in parallel, and by the single output register. A new word
// is taken in the same cycle that the waiting result is taken.
// When the receiver stalls, the result stays in the output register and
// in_ready drops until that result is taken; nothing is lost or repeated.
// Reset empties the list, rewinds the cursor and marks it not live, and
// clears the output valid flag. The element cells are not cleared; only
// cells below the element count are ever read or compared.
//
module positional_list_store_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic signed [31:0] value,
    input  logic [7:0]         position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [4:0]  found_index,
    output logic signed [31:0] element,
    output logic               has_next,
    output logic [4:0]         element_total
);
    import plsc_pkg::*;

    // List control state.
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] cursor_reg, cursor_next;
    logic             live_reg, live_next;

    // Output register.
    logic               out_valid_reg;
    status_t            status_reg, status_next;
    logic signed [4:0]  found_reg, found_next;
    logic signed [31:0] element_reg, element_next;
    logic               has_next_reg;
    logic [4:0]         total_reg;

    logic accept;
    cmd_t cmd;

    // Row of cells.
    cell_ctrl_t         cell_ctrl  [CAPACITY];
    logic signed [31:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_match;

    // Insert point, clamped to the count.
    logic [CMP_W-1:0] pos_ext, count_ext;
    logic [CNT_W-1:0] eff_pos;
    logic             full;
    logic             ins_go;

    // Search result.
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [CMP_W-1:0] hit_wide;
    logic [CMP_W-1:0] total_wide;

    // Cursor arithmetic.
    logic [CNT_W-1:0] cursor_cnt;
    logic [CNT_W-1:0] cursor_inc;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign cmd      = cmd_t'(command);

    assign pos_ext   = CMP_W'(position);
    assign count_ext = CMP_W'(count_reg);
    assign eff_pos   = (pos_ext > count_ext) ? count_reg : pos_ext[CNT_W-1:0];
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign ins_go    = accept && (cmd == CMD_INSERT) && !full;

    assign cursor_cnt = CNT_W'(cursor_reg);
    assign cursor_inc = cursor_cnt + 1'b1;

    // Each cell is told whether it is occupied, whether it is the insert
    // point, and whether it lies in the range that moves up by one.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            assign cell_ctrl[gi].occupied  = CNT_W'(gi) < count_reg;
            assign cell_ctrl[gi].load      = ins_go && (CNT_W'(gi) == eff_pos);
            assign cell_ctrl[gi].take_left = ins_go && (CNT_W'(gi) > eff_pos)
                                             && (CNT_W'(gi) <= count_reg);
            if (gi == 0)
            begin : g_head
                plsc_cell u_cell (
                    .clk        (clk),
                    .ctrl       (cell_ctrl[gi]),
                    .left_value (value),
                    .din        (value),
                    .slot_value (cell_value[gi]),
                    .match      (cell_match[gi])
                );
            end
            else
            begin : g_body
                plsc_cell u_cell (
                    .clk        (clk),
                    .ctrl       (cell_ctrl[gi]),
                    .left_value (cell_value[gi-1]),
                    .din        (value),
                    .slot_value (cell_value[gi]),
                    .match      (cell_match[gi])
                );
            end
        end
    endgenerate

    // Lowest matching cell wins: scan from the top so that lower hits
    // overwrite higher ones.
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (cell_match[i])
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign hit_wide = CMP_W'(hit_idx);

    // Next state and result for the word at the input.
    always_comb
    begin
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        live_next    = live_reg;
        status_next  = ST_OK;
        found_next   = FOUND_NONE;
        element_next = '0;
        unique case (cmd)
            CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    // An insert at or before a live cursor keeps it on the
                    // same element.
                    if (live_reg && (eff_pos <= cursor_cnt))
                    begin
                        cursor_next = cursor_reg + 1'b1;
                    end
                end
            end
            CMD_FIND:
            begin
                if (hit)
                begin
                    found_next = hit_wide[4:0];
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            CMD_REWIND:
            begin
                cursor_next = '0;
                live_next   = (count_reg != '0);
            end
            CMD_NEXT:
            begin
                if (live_reg && (cursor_cnt < count_reg))
                begin
                    element_next = cell_value[cursor_reg];
                    cursor_next  = cursor_inc[IDX_W-1:0];
                    live_next    = (cursor_inc < count_reg);
                end
                else
                begin
                    live_next   = 1'b0;
                    status_next = ST_EXHAUSTED;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign total_wide = CMP_W'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cursor_reg    <= '0;
            live_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                cursor_reg    <= cursor_next;
                live_reg      <= live_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by out_valid.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            found_reg    <= found_next;
            element_reg  <= element_next;
            has_next_reg <= live_next;
            total_reg    <= total_wide[4:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign found_index   = found_reg;
    assign element       = element_reg;
    assign has_next      = has_next_reg;
    assign element_total = total_reg;

endmodule

>>> hdl/plsc_checker.sv
// ============================================================================
// plsc_checker: port-level checks for the positional list store
// Watches the result channel and ties result fields to each other and to the
// commands that caused them.
// ============================================================================
module plsc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         status,
    input logic signed [4:0]  found_index,
    input logic signed [31:0] element,
    input logic               has_next,
    input logic [4:0]         element_total
);
    import plsc_pkg::*;

    // A stalled result word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(found_index) && $stable(element) && $stable(element_total))
        else $error("result word changed while stalled");

    // Every accepted word produces a result at the next edge.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted word gave no result");

    // A dropped insert only happens on a full list.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> (element_total == 5'(CAPACITY)))
        else $error("insert dropped on a list that is not full");

    // A failed search reports no position.
    a_notfound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NOTFOUND) |-> (found_index == FOUND_NONE))
        else $error("failed search reported a position");

    // A live cursor needs a non-empty list.
    a_live: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_next |-> (element_total != 5'd0))
        else $error("live cursor on an empty list");

endmodule

bind positional_list_store_core plsc_checker u_plsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .found_index   (found_index),
    .element       (element),
    .has_next      (has_next),
    .element_total (element_total)
);
